@@ hw/rtl/qtss_pkg.sv @@
// Shared types and constants for the quarter-turn stepper sequencer.
// Used by every module under hw/rtl; depends on nothing.
package qtss_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  localparam logic [1:0] CFG_FACE_A      = 2'd0;
  localparam logic [1:0] CFG_FACE_B      = 2'd1;
  localparam logic [1:0] CFG_FACE_C      = 2'd2;
  localparam logic [1:0] CFG_HALF_PERIOD = 2'd3;

  localparam logic [1:0] MOTOR_NONE = 2'd0;
  localparam logic [1:0] MOTOR_A    = 2'd1;
  localparam logic [1:0] MOTOR_B    = 2'd2;
  localparam logic [1:0] MOTOR_C    = 2'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] face;
    logic       prime;
    logic       dbl;
    logic       reed;
    logic [1:0] motor;
  } q_item_t;

  // first member is the top bits of the packed word
  typedef struct packed {
    logic       rejected;
    logic       busy_res;
    logic       echo_double;
    logic       echo_prime;
    logic [7:0] echo_face;
    logic       echo_valid;
    logic       led_on;
    logic       direction;
    logic [1:0] motor_select;
    logic       step_level;
  } result_t;

endpackage

@@ hw/rtl/qtss_front.sv @@
// Front end: configuration registers, input acceptance and face matching.
// Depends on qtss_pkg; feeds qtss_queue.
module qtss_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [7:0]       in_face,
  input  logic             in_prime,
  input  logic             in_dbl,
  input  logic             in_reed,
  input  logic             q_full,
  output logic             q_push,
  output qtss_pkg::q_item_t q_item,
  output logic [15:0]      half_period
);

  logic [7:0]  face_a_r, face_b_r, face_c_r;
  logic [15:0] half_period_r;
  logic [1:0]  motor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_a_r      <= 8'd0;
      face_b_r      <= 8'd0;
      face_c_r      <= 8'd0;
      half_period_r <= qtss_pkg::HALF_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qtss_pkg::CFG_FACE_A:      face_a_r      <= cfg_data[7:0];
        qtss_pkg::CFG_FACE_B:      face_b_r      <= cfg_data[7:0];
        qtss_pkg::CFG_FACE_C:      face_c_r      <= cfg_data[7:0];
        qtss_pkg::CFG_HALF_PERIOD: half_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A wins over B, B over C; a zero face never matches
  always_comb begin
    priority if (in_face != 8'd0 && in_face == face_a_r) begin
      motor = qtss_pkg::MOTOR_A;
    end else if (in_face != 8'd0 && in_face == face_b_r) begin
      motor = qtss_pkg::MOTOR_B;
    end else if (in_face != 8'd0 && in_face == face_c_r) begin
      motor = qtss_pkg::MOTOR_C;
    end else begin
      motor = qtss_pkg::MOTOR_NONE;
    end
  end

  assign in_ready     = !q_full;
  assign q_push       = in_valid && !q_full;
  assign q_item.op    = in_op;
  assign q_item.face  = in_face;
  assign q_item.prime = in_prime;
  assign q_item.dbl   = in_dbl;
  assign q_item.reed  = in_reed;
  assign q_item.motor = motor;
  assign half_period  = half_period_r;

endmodule

@@ hw/rtl/qtss_queue.sv @@
// Short queue of classified words between front and back.
// Depends on qtss_pkg.
module qtss_queue #(
  parameter int unsigned DEPTH = qtss_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qtss_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output qtss_pkg::q_item_t pop_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  qtss_pkg::q_item_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/qtss_back.sv @@
// Back end: move sequencing, step timing, reed sampling and result register.
// Depends on qtss_pkg; drains qtss_queue.
module qtss_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  qtss_pkg::q_item_t q_item,
  output logic              q_pop,
  input  logic [15:0]       half_period,
  output logic              out_valid,
  input  logic              out_ready,
  output qtss_pkg::result_t out_res
);

  typedef enum logic [1:0] {PH_IDLE, PH_LEAVE, PH_SEEK} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  last_face_r, last_face_nxt;
  logic        last_prime_r, last_prime_nxt;
  logic        last_double_r, last_double_nxt;
  logic        last_seen_r, last_seen_nxt;
  logic [1:0]  motor_r, motor_nxt;
  logic        dir_r, dir_nxt;
  logic [1:0]  turns_r, turns_nxt, turns_dec;
  logic [15:0] cnt_r, cnt_nxt, half_m1;
  logic        step_r, step_nxt;
  logic        led_r, led_nxt;
  logic        echo, rej, dup;
  logic        out_valid_r;
  qtss_pkg::result_t out_r, out_nxt;

  assign half_m1   = (half_period == 16'd0) ? 16'd0 : half_period - 16'd1;
  assign turns_dec = (turns_r != 2'd0) ? turns_r - 2'd1 : turns_r;
  assign dup       = last_seen_r && q_item.face == last_face_r &&
                     q_item.prime == last_prime_r && q_item.dbl == last_double_r;
  assign q_pop     = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    phase_nxt       = phase_r;
    last_face_nxt   = last_face_r;
    last_prime_nxt  = last_prime_r;
    last_double_nxt = last_double_r;
    last_seen_nxt   = last_seen_r;
    motor_nxt       = motor_r;
    dir_nxt         = dir_r;
    turns_nxt       = turns_r;
    cnt_nxt         = cnt_r;
    step_nxt        = step_r;
    led_nxt         = led_r;
    echo            = 1'b0;
    rej             = 1'b0;
    if (q_item.op == qtss_pkg::OP_TICK) begin
      if (phase_r != PH_IDLE) begin
        if (cnt_r != 16'd0) begin
          cnt_nxt = cnt_r - 16'd1;
        end else if (step_r) begin
          step_nxt = 1'b0;
          cnt_nxt  = half_m1;
        end else if (phase_r == PH_LEAVE && !q_item.reed) begin
          step_nxt = 1'b1;
          cnt_nxt  = half_m1;
        end else if (q_item.reed) begin
          phase_nxt = PH_SEEK;
          step_nxt  = 1'b1;
          cnt_nxt   = half_m1;
        end else if (turns_dec == 2'd0) begin
          turns_nxt = turns_dec;
          phase_nxt = PH_IDLE;
          motor_nxt = qtss_pkg::MOTOR_NONE;
          echo      = 1'b1;
        end else begin
          turns_nxt = turns_dec;
          phase_nxt = PH_LEAVE;
          step_nxt  = 1'b1;
          cnt_nxt   = half_m1;
        end
      end
    end else if (phase_r != PH_IDLE) begin
      rej = 1'b1;
    end else if (!dup) begin
      last_face_nxt   = q_item.face;
      last_prime_nxt  = q_item.prime;
      last_double_nxt = q_item.dbl;
      last_seen_nxt   = 1'b1;
      if (q_item.motor == qtss_pkg::MOTOR_NONE) begin
        led_nxt = 1'b0;
      end else begin
        led_nxt   = 1'b1;
        motor_nxt = q_item.motor;
        dir_nxt   = !q_item.prime;
        turns_nxt = q_item.dbl ? 2'd2 : 2'd1;
        phase_nxt = PH_LEAVE;
        cnt_nxt   = 16'd0;
        step_nxt  = 1'b0;
      end
    end
    out_nxt.step_level   = step_nxt;
    out_nxt.motor_select = motor_nxt;
    out_nxt.direction    = dir_nxt;
    out_nxt.led_on       = led_nxt;
    out_nxt.echo_valid   = echo;
    out_nxt.echo_face    = echo ? last_face_nxt : 8'd0;
    out_nxt.echo_prime   = echo && last_prime_nxt;
    out_nxt.echo_double  = echo && last_double_nxt;
    out_nxt.busy_res     = (phase_nxt != PH_IDLE);
    out_nxt.rejected     = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      last_face_r   <= 8'd0;
      last_prime_r  <= 1'b0;
      last_double_r <= 1'b0;
      last_seen_r   <= 1'b0;
      motor_r       <= qtss_pkg::MOTOR_NONE;
      dir_r         <= 1'b0;
      turns_r       <= 2'd0;
      cnt_r         <= 16'd0;
      step_r        <= 1'b0;
      led_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      out_r         <= '0;
    end else begin
      if (q_pop) begin
        phase_r       <= phase_nxt;
        last_face_r   <= last_face_nxt;
        last_prime_r  <= last_prime_nxt;
        last_double_r <= last_double_nxt;
        last_seen_r   <= last_seen_nxt;
        motor_r       <= motor_nxt;
        dir_r         <= dir_nxt;
        turns_r       <= turns_nxt;
        cnt_r         <= cnt_nxt;
        step_r        <= step_nxt;
        led_r         <= led_nxt;
        out_valid_r   <= 1'b1;
        out_r         <= out_nxt;
      end else if (out_ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_idle_no_motor: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) == (motor_r == qtss_pkg::MOTOR_NONE))
    else $error("motor selected while idle or none while running");

  a_step_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_r |-> (phase_r != PH_IDLE))
    else $error("step high while idle");

  a_echo_ends_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.echo_valid) |-> !out_r.busy_res)
    else $error("echo while still busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.rejected) |-> out_r.busy_res)
    else $error("reject while idle");

  a_turns_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (turns_r != 2'd0))
    else $error("running with no turns left");

endmodule

@@ hw/rtl/quarter_turn_stepper_sequencer_top.sv @@
// Top level of the quarter-turn stepper sequencer: streaming ports and wiring.
// Depends on qtss_pkg, qtss_front, qtss_queue and qtss_back.
//
// Takes one word per clock on the in_ stream while in_tready is high, either a
// tick carrying the reed level (in_tuser low) or a move command (in_tuser high),
// and returns exactly one result word per input word on the out_ stream, in
// order. A word passes the front classifier into a queue of QUEUE_DEPTH words
// and is executed by the back end one word per cycle while the result register
// is free, so the sustained rate is one word per clock; each word is held in
// the queue memory, then in the result register. The back end's single state
// update per word sets that rate. The result register frees as it is taken,
// and the queue absorbs output stalls of up to QUEUE_DEPTH words before in_tready
// drops. Configuration writes are always taken and belong in idle periods.
module quarter_turn_stepper_sequencer_top #(
  parameter int unsigned QUEUE_DEPTH = qtss_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // move_face[7:0], move_prime[8], move_double[9], reed_level[10], zero[15:11]
  input  logic [15:0] in_tdata,
  // op[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // step_level[0], motor_select[2:1], direction[3], led_on[4], echo_valid[5],
  // echo_face[13:6], echo_prime[14], echo_double[15], busy_res[16],
  // rejected[17], zero[23:18]
  output logic [23:0] out_tdata
);

  qtss_pkg::q_item_t push_item, pop_item;
  qtss_pkg::result_t res;
  logic        q_full, q_push, q_pop, q_not_empty;
  logic [15:0] half_period;

  qtss_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser),
    .in_face     (in_tdata[7:0]),
    .in_prime    (in_tdata[8]),
    .in_dbl      (in_tdata[9]),
    .in_reed     (in_tdata[10]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (push_item),
    .half_period (half_period)
  );

  qtss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  qtss_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_not_empty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .half_period (half_period),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res)
  );

  assign out_tdata = {6'd0, res};

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for quarter_turn_stepper_sequencer_top: directed and random
// tick/move streams, checked word by word against an in-bench predictor.
// Depends on qtss_pkg and the sequencer RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {MOTION_IDLE, MOTION_LEAVE, MOTION_SEEK} motion_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = qtss_pkg::CFG_FACE_A;
  logic [15:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = qtss_pkg::OP_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  quarter_turn_stepper_sequencer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // predictor copy of registers and sequencer state
  logic [7:0]  code_a = '0, code_b = '0, code_c = '0;
  logic [15:0] half_ticks = qtss_pkg::HALF_PERIOD_RESET;
  logic [7:0]  prev_face = '0;
  logic        prev_prime = 1'b0, prev_dbl = 1'b0, prev_known = 1'b0;
  motion_t     motion = MOTION_IDLE;
  logic [1:0]  motor = qtss_pkg::MOTOR_NONE;
  logic        clockwise = 1'b0;
  logic [1:0]  turns_left = '0;
  logic [15:0] half_count = '0;
  logic        step_high = 1'b0;
  logic        led = 1'b0;

  qtss_pkg::result_t sequencer_results_due[$];
  qtss_pkg::result_t rx_want, rx_got;
  int unsigned words_sent = 0, moves_done = 0, cmds_refused = 0, fail_count = 0;
  int unsigned next_gap = 0, in_gap_max = 0, out_stall_max = 0, rx_hold = 0, rx_stall = 0;
  logic        in_held = 1'b0;

  initial forever #4 clk = ~clk;

  initial begin
    #(6_000_000);
    $display("tb failed");
    $finish;
  end

  function automatic logic [15:0] reload_count();
    return (half_ticks == 16'd0) ? 16'd0 : half_ticks - 16'd1;
  endfunction

  function automatic logic sample_due();
    return motion != MOTION_IDLE && !step_high && half_count == 16'd0;
  endfunction

  function automatic qtss_pkg::result_t step_sequencer(logic op, logic [7:0] face,
                                                       logic prime, logic dbl, logic reed);
    qtss_pkg::result_t r;
    logic       done;
    logic       dropped;
    logic [1:0] pick;
    done    = 1'b0;
    dropped = 1'b0;
    pick    = qtss_pkg::MOTOR_NONE;
    if (op == qtss_pkg::OP_TICK) begin
      if (motion != MOTION_IDLE) begin
        if (step_high) begin
          if (half_count != 16'd0) begin
            half_count = half_count - 16'd1;
          end else begin
            step_high  = 1'b0;
            half_count = reload_count();
          end
        end else if (half_count != 16'd0) begin
          half_count = half_count - 16'd1;
        end else if (reed || motion == MOTION_LEAVE) begin
          if (reed) motion = MOTION_SEEK;
          step_high  = 1'b1;
          half_count = reload_count();
        end else begin
          if (turns_left != 2'd0) turns_left = turns_left - 2'd1;
          if (turns_left == 2'd0) begin
            motion = MOTION_IDLE;
            motor  = qtss_pkg::MOTOR_NONE;
            done   = 1'b1;
          end else begin
            motion     = MOTION_LEAVE;
            step_high  = 1'b1;
            half_count = reload_count();
          end
        end
      end
    end else if (motion != MOTION_IDLE) begin
      dropped = 1'b1;
    end else if (!(prev_known && face == prev_face && prime == prev_prime &&
                   dbl == prev_dbl)) begin
      prev_face  = face;
      prev_prime = prime;
      prev_dbl   = dbl;
      prev_known = 1'b1;
      if (face != 8'd0 && face == code_a) pick = qtss_pkg::MOTOR_A;
      else if (face != 8'd0 && face == code_b) pick = qtss_pkg::MOTOR_B;
      else if (face != 8'd0 && face == code_c) pick = qtss_pkg::MOTOR_C;
      if (pick == qtss_pkg::MOTOR_NONE) begin
        led = 1'b0;
      end else begin
        led        = 1'b1;
        motor      = pick;
        clockwise  = !prime;
        turns_left = dbl ? 2'd2 : 2'd1;
        motion     = MOTION_LEAVE;
        half_count = 16'd0;
        step_high  = 1'b0;
      end
    end
    r.step_level   = step_high;
    r.motor_select = motor;
    r.direction    = clockwise;
    r.led_on       = led;
    r.echo_valid   = done;
    r.echo_face    = done ? prev_face : 8'd0;
    r.echo_prime   = done ? prev_prime : 1'b0;
    r.echo_double  = done ? prev_dbl : 1'b0;
    r.busy_res     = motion != MOTION_IDLE;
    r.rejected     = dropped;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // result side: check each word, then draw a stall; a long hold takes precedence
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (sequencer_results_due.size() == 0) begin
          $display("%0t unexpected word: expected none, got %h", $time, out_tdata);
          fail_count++;
        end else begin
          rx_want = sequencer_results_due.pop_front();
          rx_got  = qtss_pkg::result_t'(out_tdata[17:0]);
          compare_field("step_level", 8'(rx_want.step_level), 8'(rx_got.step_level));
          compare_field("motor_select", 8'(rx_want.motor_select),
                        8'(rx_got.motor_select));
          compare_field("direction", 8'(rx_want.direction), 8'(rx_got.direction));
          compare_field("led_on", 8'(rx_want.led_on), 8'(rx_got.led_on));
          compare_field("echo_valid", 8'(rx_want.echo_valid), 8'(rx_got.echo_valid));
          compare_field("echo_face", rx_want.echo_face, rx_got.echo_face);
          compare_field("echo_prime", 8'(rx_want.echo_prime), 8'(rx_got.echo_prime));
          compare_field("echo_double", 8'(rx_want.echo_double), 8'(rx_got.echo_double));
          compare_field("busy_res", 8'(rx_want.busy_res), 8'(rx_got.busy_res));
          compare_field("rejected", 8'(rx_want.rejected), 8'(rx_got.rejected));
        end
        rx_stall = $urandom_range(0, out_stall_max);
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic op, logic [7:0] face, logic prime, logic dbl, logic reed);
    qtss_pkg::result_t r;
    if (next_gap != 0) repeat (next_gap) @(posedge clk);
    r = step_sequencer(op, face, prime, dbl, reed);
    if (r.echo_valid) moves_done++;
    if (r.rejected) cmds_refused++;
    sequencer_results_due.push_back(r);
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, reed, dbl, prime, face};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    next_gap = $urandom_range(0, in_gap_max);
    in_held  = (next_gap == 0);
    if (next_gap != 0) in_tvalid <= 1'b0;
  endtask

  task automatic send_tick(logic reed);
    send_word(qtss_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), reed);
  endtask

  task automatic send_move(logic [7:0] face, logic prime, logic dbl);
    send_word(qtss_pkg::OP_MOVE, face, prime, dbl, 1'($urandom_range(0, 1)));
  endtask

  // drop valid if still held, then wait out every outstanding word
  task automatic drain_results();
    if (in_held) begin
      in_tvalid <= 1'b0;
      in_held = 1'b0;
    end
    while (sequencer_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      qtss_pkg::CFG_FACE_A:      code_a = val[7:0];
      qtss_pkg::CFG_FACE_B:      code_b = val[7:0];
      qtss_pkg::CFG_FACE_C:      code_c = val[7:0];
      qtss_pkg::CFG_HALF_PERIOD: half_ticks = val;
      default: ;
    endcase
  endtask

  task automatic set_faces(logic [7:0] fa, logic [7:0] fb, logic [7:0] fc, logic [15:0] hp);
    write_reg(qtss_pkg::CFG_FACE_A, {8'd0, fa});
    write_reg(qtss_pkg::CFG_FACE_B, {8'd0, fb});
    write_reg(qtss_pkg::CFG_FACE_C, {8'd0, fc});
    write_reg(qtss_pkg::CFG_HALF_PERIOD, hp);
  endtask

  // tick with random reed until the move ends; inject stray commands now and then
  task automatic run_to_idle(int unsigned stray_pct);
    while (motion != MOTION_IDLE) begin
      if ($urandom_range(0, 99) < stray_pct)
        send_move(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      else
        send_tick(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_idle_behavior();
    send_tick(1'b1);
    send_tick(1'b0);
    send_move(8'h52, 1'b0, 1'b0);
    send_move(8'h52, 1'b0, 1'b0);
    send_move(8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_single_and_double_turns();
    set_faces(8'hFF, 8'h01, 8'h80, 16'h0000);
    in_gap_max    = 7;
    out_stall_max = 7;
    send_move(8'hFF, 1'b0, 1'b0);
    send_tick(1'b0);
    send_move(8'h01, 1'b1, 1'b1);
    run_to_idle(0);
    send_move(8'hFF, 1'b0, 1'b0);
    send_move(8'h01, 1'b1, 1'b1);
    run_to_idle(0);
    send_move(8'h7E, 1'b0, 1'b1);
  endtask

  task automatic test_face_priority();
    set_faces(8'h00, 8'h33, 8'h33, 16'd1);
    send_move(8'h00, 1'b0, 1'b0);
    send_move(8'h33, 1'b1, 1'b0);
    run_to_idle(0);
    set_faces(8'h33, 8'h33, 8'h33, 16'd2);
    send_move(8'h33, 1'b0, 1'b0);
    run_to_idle(0);
  endtask

  task automatic test_output_backpressure();
    drain_results();
    in_gap_max    = 0;
    out_stall_max = 0;
    rx_hold       = 64;
    send_move(8'h33, 1'b1, 1'b1);
    run_to_idle(0);
    repeat (8) send_tick(1'($urandom_range(0, 1)));
    drain_results();
  endtask

  task automatic test_long_half_period();
    set_faces(8'hFF, 8'h01, 8'h80, 16'd40);
    in_gap_max    = 0;
    out_stall_max = 0;
    send_move(8'h80, 1'b1, 1'b0);
    send_tick(1'b1);
    while (motion != MOTION_IDLE) begin
      if (sample_due()) send_tick(1'b0);
      else send_tick(1'($urandom_range(0, 1)));
    end
    write_reg(qtss_pkg::CFG_HALF_PERIOD, 16'd1);
  endtask

  function automatic logic [7:0] pick_face();
    case ($urandom_range(0, 3))
      0: return code_a;
      1: return code_b;
      2: return code_c;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_random_phases();
    int unsigned k, r, stop_at;
    logic [7:0]  fa, fb, fc;
    logic [15:0] hp;
    for (k = 0; k < 6; k++) begin
      fa = 8'($urandom_range(0, 255));
      fb = 8'($urandom_range(0, 255));
      fc = 8'($urandom_range(0, 255));
      case (k)
        0: begin
          fa = 8'($urandom_range(1, 255));
          fb = 8'($urandom_range(1, 255));
          fc = 8'($urandom_range(1, 255));
        end
        1: begin
          fa = 8'd0;
          fb = 8'($urandom_range(1, 255));
          fc = fb;
        end
        2: begin
          fa = 8'($urandom_range(1, 255));
          fb = fa;
          fc = fa;
        end
        4: begin
          fa = 8'hFF;
          fb = 8'h01;
          fc = 8'h80;
        end
        default: ;
      endcase
      hp = (k == 2) ? 16'd0 : (k == 5) ? 16'd3 : 16'($urandom_range(1, 2));
      set_faces(fa, fb, fc, hp);
      in_gap_max    = (k == 2 || k == 4) ? 0 : 7;
      out_stall_max = (k == 1 || k == 4) ? 0 : 7;
      stop_at = words_sent + 210;
      while (words_sent < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          send_move(pick_face(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          run_to_idle(4);
        end else if (r < 75) begin
          send_move(prev_face, prev_prime, prev_dbl);
        end else if (r < 85) begin
          send_move(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          run_to_idle(4);
        end else begin
          repeat ($urandom_range(1, 4)) send_tick(1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_behavior();
    test_single_and_double_turns();
    test_face_priority();
    test_output_backpressure();
    test_long_half_period();
    test_random_phases();
    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d words, %0d moves finished, %0d commands refused while busy",
             words_sent, moves_done, cmds_refused);
    $display("settings spanned zero, small and long half periods and shared face codes");
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
